// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the circular event logger.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, switched off during reset.
`define CSEL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CSEL_ASSERT_NEXT(lbl, ante, cons, msg) \
	`CSEL_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hw/rtl/csel_pkg.sv
// Types, constants and the record packing function of the circular event logger.
// Depends on nothing.
package csel_pkg;

	localparam int LOG_DEPTH = 1024;
	localparam int SLOT_W    = $clog2(LOG_DEPTH);
	localparam int HELD_W    = $clog2(LOG_DEPTH + 1);
	localparam int POS_W     = 10;
	localparam int SUM_W     = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;
	localparam int CMP_W     = (HELD_W > POS_W) ? HELD_W : POS_W;
	localparam int COUNT_W   = 16;
	localparam int REC_W     = 64;

	localparam logic [1:0] OP_SAVE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ERR_SOFT = 2'd1;
	localparam logic [1:0] ERR_HARD = 2'd2;

	typedef struct packed {
		logic [7:0]  range_low;
		logic [7:0]  range_high;
		logic [7:0]  status_b;
		logic [7:0]  status_a;
		logic [31:0] meter;
	} record_t;

	// Builds the 64-bit record of a save from the meter value and the raw alarm, error, day and range fields.
	function automatic record_t pack_record(
		input logic [31:0] meter,
		input logic [9:0]  flags,
		input logic [1:0]  valve_err,
		input logic [1:0]  check_err,
		input logic [7:0]  day,
		input logic [7:0]  rng_high,
		input logic [7:0]  rng_low
	);
		record_t r;
		r.meter      = meter;
		r.status_a   = {flags[9], flags[8], flags[7], flags[6],
		                (|flags[5:4]), (|flags[3:2]), flags[1],
		                ((valve_err == ERR_HARD) || (check_err == ERR_HARD))};
		r.status_b   = {(valve_err == ERR_SOFT), flags[0], day[5:0]};
		r.range_high = rng_high;
		r.range_low  = rng_low;
		return r;
	endfunction

endpackage

// File: hw/rtl/circular_status_event_logger.sv
// Top level of the circular event logger: pointer logic, record store and result register.
// Depends on csel_pkg, csel_ram and assert_macros.svh.
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      op, meter_value, event_flags, error codes,
//                                                day_count, range bytes, read_position
// result    out        done high for one cycle   out_meter_value, status bytes, range bytes,
//                                                entry_valid, entries_held, total_saved
//
// Each item's result appears on the cycle after it is taken, so a new item may be issued
// on every cycle; the result comes from the result register or the registered read port
// of the record RAM. busy is therefore never raised.
// Reset clears the write slot, the wrap flag, the save count and the result strobe; the
// record RAM is not cleared, since a read can only reach slots that have been written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module circular_status_event_logger (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] meter_value,
	input  logic [9:0]  event_flags,
	input  logic [1:0]  valve_error_status,
	input  logic [1:0]  check_error_status,
	input  logic [7:0]  day_count,
	input  logic [7:0]  range_high,
	input  logic [7:0]  range_low,
	input  logic [9:0]  read_position,

	output logic        done,
	output logic [31:0] out_meter_value,
	output logic [7:0]  status_byte_a,
	output logic [7:0]  status_byte_b,
	output logic [7:0]  out_range_high,
	output logic [7:0]  out_range_low,
	output logic        entry_valid,
	output logic [10:0] entries_held,
	output logic [15:0] total_saved
);

	localparam int SLOT_W  = csel_pkg::SLOT_W;
	localparam int HELD_W  = csel_pkg::HELD_W;
	localparam int SUM_W   = csel_pkg::SUM_W;
	localparam int CMP_W   = csel_pkg::CMP_W;
	localparam int COUNT_W = csel_pkg::COUNT_W;

	localparam logic [SLOT_W:0] DEPTH_SLOT = (SLOT_W + 1)'(csel_pkg::LOG_DEPTH);
	localparam logic [HELD_W-1:0] DEPTH_HELD = HELD_W'(csel_pkg::LOG_DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(csel_pkg::LOG_DEPTH);

	// Pointer state. The write slot is always below the depth, so it never needs
	// the range check on entry that a free-running count would.
	logic [SLOT_W-1:0]  write_slot_q;
	logic               wrapped_q;
	logic [COUNT_W-1:0] save_count_q;

	logic [SLOT_W-1:0]  write_slot_d;
	logic               wrapped_d;
	logic [COUNT_W-1:0] save_count_d;
	logic [HELD_W-1:0]  held_now;
	logic [HELD_W-1:0]  held_d;

	logic accept;
	logic is_save;
	logic is_read;
	logic is_clear;

	logic [SLOT_W:0]   slot_inc;
	logic [SUM_W-1:0]  idx_sum;
	logic [SUM_W-1:0]  idx_wrap;
	logic [SLOT_W-1:0] read_idx;
	logic              read_hit;

	csel_pkg::record_t new_rec;
	logic [csel_pkg::REC_W-1:0] ram_rdata;

	// Result register.
	logic               done_s1;
	logic               valid_s1;
	logic               from_ram_s1;
	csel_pkg::record_t  rec_s1;
	logic [HELD_W-1:0]  held_s1;
	logic [COUNT_W-1:0] count_s1;

	csel_pkg::record_t out_rec;

	// Every item completes in one pass, so the block is always ready.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_save  = (op == csel_pkg::OP_SAVE);
	assign is_read  = (op == csel_pkg::OP_READ);
	assign is_clear = (op == csel_pkg::OP_CLEAR);

	assign new_rec = csel_pkg::pack_record(meter_value, event_flags, valve_error_status,
		check_error_status, day_count, range_high, range_low);

	assign held_now = wrapped_q ? DEPTH_HELD : HELD_W'(write_slot_q);

	// A read is only honoured below the number of records held, which keeps it
	// away from slots never written.
	assign read_hit = is_read && (CMP_W'(read_position) < CMP_W'(held_now));

	// Once wrapped, position zero is the slot about to be overwritten. The sum stays
	// below twice the depth for any honoured read, so one subtraction suffices.
	assign idx_sum  = wrapped_q ? (SUM_W'(write_slot_q) + SUM_W'(read_position))
	                            : SUM_W'(read_position);
	assign idx_wrap = (idx_sum >= DEPTH_SUM) ? (idx_sum - DEPTH_SUM) : idx_sum;
	assign read_idx = idx_wrap[SLOT_W-1:0];

	assign slot_inc = (SLOT_W + 1)'(write_slot_q) + (SLOT_W + 1)'(1);

	always_comb begin
		write_slot_d = write_slot_q;
		wrapped_d    = wrapped_q;
		save_count_d = save_count_q;
		priority if (is_save) begin
			if (slot_inc == DEPTH_SLOT) begin
				write_slot_d = '0;
				wrapped_d    = 1'b1;
			end else begin
				write_slot_d = slot_inc[SLOT_W-1:0];
			end
			save_count_d = save_count_q + COUNT_W'(1);
		end else if (is_clear) begin
			write_slot_d = '0;
			wrapped_d    = 1'b0;
			save_count_d = '0;
		end else begin
			write_slot_d = write_slot_q;
		end
	end

	assign held_d = wrapped_d ? DEPTH_HELD : HELD_W'(write_slot_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			wrapped_q    <= 1'b0;
			save_count_q <= '0;
		end else if (accept) begin
			write_slot_q <= write_slot_d;
			wrapped_q    <= wrapped_d;
			save_count_q <= save_count_d;
		end
	end

	// The save's write lands at the edge that takes it; a read issued on the following cycle
	// samples the RAM at its own edge, so back-to-back save and read of one slot need no bypass.
	csel_ram #(
		.DEPTH (csel_pkg::LOG_DEPTH),
		.WIDTH (csel_pkg::REC_W)
	) u_ram (
		.clk   (clk),
		.we    (accept && is_save),
		.waddr (write_slot_q),
		.wdata (new_rec),
		.re    (accept && read_hit),
		.raddr (read_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			valid_s1    <= is_save || read_hit;
			from_ram_s1 <= is_read;
			rec_s1      <= new_rec;
			held_s1     <= held_d;
			count_s1    <= save_count_d;
		end
	end

	// A save reports the record it stored; a read reports the RAM word; anything
	// that returns no record shows zeros.
	always_comb begin
		if (!valid_s1) begin
			out_rec = '0;
		end else if (from_ram_s1) begin
			out_rec = csel_pkg::record_t'(ram_rdata);
		end else begin
			out_rec = rec_s1;
		end
	end

	assign done            = done_s1;
	assign out_meter_value = out_rec.meter;
	assign status_byte_a   = out_rec.status_a;
	assign status_byte_b   = out_rec.status_b;
	assign out_range_high  = out_rec.range_high;
	assign out_range_low   = out_rec.range_low;
	assign entry_valid     = valid_s1;
	assign entries_held    = held_s1;
	assign total_saved     = count_s1;

	`CSEL_ASSERT_NEXT(a_result_follows, accept, done,
		"accepted item produced no result on the next cycle")
	`CSEL_ASSERT(a_held_bounded, done |-> (entries_held <= DEPTH_HELD),
		"entries held exceeds the log depth")
	`CSEL_ASSERT_NEXT(a_clear_zeroes, accept && is_clear,
		(entries_held == '0) && (total_saved == '0) && !entry_valid,
		"clear did not report an empty log")
	`CSEL_ASSERT(a_invalid_zero, (done && !entry_valid) |->
		((out_meter_value == '0) && (status_byte_a == '0) && (status_byte_b == '0)
		&& (out_range_high == '0) && (out_range_low == '0)),
		"result without a record carries non-zero record fields")

endmodule

// File: hw/rtl/csel_ram.sv
// Simple dual-port synchronous RAM with registered read data.
// Depends on nothing; sized by its parameters.
module csel_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
